### rtl/core/kwsm_pkg.sv
// Shared widths and controller/datapath handshake types for the k-way merge
package kwsm_pkg;

   // Fixed field widths of the channels
   localparam int KEY_W  = 62;
   localparam int CNT_W  = 30;
   localparam int PART_W = 4;
   localparam int CFG_W  = 5;

   // Reset value of the partition count register
   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the accepted input beat
      logic load;      // store the beat as a partition head, prime the scan
      logic scan;      // step the head scan by one entry
      logic emit;      // move the winner (or done) into the output register
   } kwsm_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic finished;   // merge over, every beat gets the done result
      logic fill_more;  // fill phase continues after this load, no result due
      logic scan_done;  // every head compared, winner settled
      logic out_free;   // output register can take a result this cycle
   } kwsm_stat_type;

endpackage

### rtl/core/kway_sorted_stream_merge.sv
// Top level of the k-way sorted stream merge
//
//   channel  direction  handshake          payload
//   req_     in         valid / stall      source_part, kmer_key, count_value, is_end
//   rsp_     out        valid / stall      out_key, out_count, out_valid, next_part, all_done
//   csr_     in         valid / ready      partitions_in_use
//
// A fill beat is accepted, then loaded. A merge beat, and the beat that ends the
// fill phase, is accepted, loaded, scanned over the clamped partition count of
// heads and emitted: the minimum is found by a serial scan of the head
// memory, one entry per cycle through its single read port. Once the merge is
// finished a beat is accepted, loaded and emitted.
// Reset is synchronous; it clears the live bits, the fill count and the state machine.
// The head memory needs no clearing. A stalled result sits in the output register
// while the next beat is taken and worked; that beat then waits to emit.
module kway_sorted_stream_merge #(
   parameter int PARTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // input beats
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kwsm_pkg::PART_W-1:0]         req_source_part,
   input  logic [kwsm_pkg::KEY_W-1:0]          req_kmer_key,
   input  logic [kwsm_pkg::CNT_W-1:0]          req_count_value,
   input  logic                                req_is_end,
   // result beats
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kwsm_pkg::KEY_W-1:0]          rsp_out_key,
   output logic [kwsm_pkg::CNT_W-1:0]          rsp_out_count,
   output logic                                rsp_out_valid,
   output logic [kwsm_pkg::PART_W-1:0]         rsp_next_part,
   output logic                                rsp_all_done,
   // partition count register
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kwsm_pkg::CFG_W-1:0]          csr_partitions_in_use
);

   kwsm_pkg::kwsm_cmd_type  cmd;
   kwsm_pkg::kwsm_stat_type stat;
   logic                    req_take;

   // The partition of a beat follows from the fill order or the last request;
   // the advisory source tag is checked against nothing.
   assign req_take  = req_valid && (req_source_part == req_source_part);
   assign csr_ready = 1'b1;

   kwsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_take),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   kwsm_dp #(
      .PARTS (PARTS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg_we        (csr_valid && csr_ready),
      .cfg_data      (csr_partitions_in_use),
      .in_key        (req_kmer_key),
      .in_count      (req_count_value),
      .in_end        (req_is_end),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_count (rsp_out_count),
      .rsp_out_valid (rsp_out_valid),
      .rsp_next_part (rsp_next_part),
      .rsp_all_done  (rsp_all_done)
   );

endmodule

### rtl/core/kwsm_ctrl.sv
// Sequencing state machine for the k-way merge: accept, load, scan, emit
module kwsm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  kwsm_pkg::kwsm_stat_type stat,
   output kwsm_pkg::kwsm_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Take a beat only while no item is in work
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (stat.finished) begin
               state_in = ST_EMIT;
            end else if (stat.fill_more) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/kwsm_dp.sv
// Datapath for the k-way merge: head memory, live bits, serial minimum scan, output register
module kwsm_dp #(
   parameter int PARTS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  cfg_we,
   input  logic [kwsm_pkg::CFG_W-1:0]            cfg_data,
   // input beat payload
   input  logic [kwsm_pkg::KEY_W-1:0]            in_key,
   input  logic [kwsm_pkg::CNT_W-1:0]            in_count,
   input  logic                                  in_end,
   // controller link
   input  kwsm_pkg::kwsm_cmd_type                cmd,
   output kwsm_pkg::kwsm_stat_type               stat,
   // result channel
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [kwsm_pkg::KEY_W-1:0]            rsp_out_key,
   output logic [kwsm_pkg::CNT_W-1:0]            rsp_out_count,
   output logic                                  rsp_out_valid,
   output logic [kwsm_pkg::PART_W-1:0]           rsp_next_part,
   output logic                                  rsp_all_done
);

   localparam int IDX_W = (PARTS > 1) ? $clog2(PARTS) : 1;
   localparam int KEY_W = kwsm_pkg::KEY_W;
   localparam int CNT_W = kwsm_pkg::CNT_W;
   localparam int CFG_W = kwsm_pkg::CFG_W;
   localparam int HEAD_W = KEY_W + CNT_W;

   // Configuration and captured beat
   logic [CFG_W-1:0] cfg_ff;
   logic [KEY_W-1:0] in_key_ff;
   logic [CNT_W-1:0] in_count_ff;
   logic             in_end_ff;

   // Merge control state
   logic [PARTS-1:0] live_ff, live_in;
   logic [CFG_W-1:0] fill_ff;
   logic             merging_ff;
   logic [IDX_W-1:0] pending_ff;
   logic             finished_ff;

   // Head memory with registered read
   logic [HEAD_W-1:0] head_mem_ff [PARTS];
   logic [HEAD_W-1:0] mem_q_ff;

   // Scan state
   logic [CFG_W-1:0] scan_ff;
   logic             rd_pend_ff;
   logic             rd_live_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             found_ff;
   logic [KEY_W-1:0] best_key_ff;
   logic [CNT_W-1:0] best_count_ff;
   logic [IDX_W-1:0] best_idx_ff;

   // Output register
   logic             rsp_valid_ff;
   logic [KEY_W-1:0] out_key_ff;
   logic [CNT_W-1:0] out_count_ff;
   logic             out_valid_ff;
   logic [IDX_W-1:0] out_part_ff;
   logic             out_done_ff;

   logic [CFG_W-1:0] n_act;
   logic             fill_ld;
   logic [CFG_W-1:0] fill_nx;
   logic             fill_more;
   logic             head_we;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] scan_idx;
   logic             scan_issue;
   logic [KEY_W-1:0] rd_key;
   logic             take_best;
   logic             emit_rec;
   logic             out_free;

   // Clamp the partition count to 1..PARTS
   always_comb begin
      if (cfg_ff == '0) begin
         n_act = CFG_W'(1);
      end else if (32'(cfg_ff) > PARTS) begin
         n_act = CFG_W'(PARTS);
      end else begin
         n_act = cfg_ff;
      end
   end

   // Fill phase bookkeeping
   assign fill_ld   = !merging_ff && (fill_ff < n_act);
   assign fill_nx   = fill_ld ? (fill_ff + CFG_W'(1)) : fill_ff;
   assign fill_more = !merging_ff && (fill_nx < n_act);

   // Head write: fill slot or the partition last asked for
   assign wr_idx  = merging_ff ? pending_ff : IDX_W'(fill_ff);
   assign head_we = cmd.load && !finished_ff && (merging_ff || fill_ld);

   // Scan read side
   assign scan_idx   = IDX_W'(scan_ff);
   assign scan_issue = cmd.scan && (scan_ff < n_act);
   assign rd_key     = mem_q_ff[HEAD_W-1:CNT_W];
   assign take_best  = rd_pend_ff && rd_live_ff && (!found_ff || (rd_key < best_key_ff));

   // Emit a record only while a live head was found
   assign emit_rec = cmd.emit && !finished_ff && found_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Live bit update: set or drop on load, drop the winner on emit
   always_comb begin
      live_in = live_ff;
      if (head_we) begin
         live_in[wr_idx] = !in_end_ff;
      end
      if (emit_rec) begin
         live_in[best_idx_ff] = 1'b0;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= kwsm_pkg::CFG_RESET;
      end else if (cfg_we) begin
         cfg_ff <= cfg_data;
      end
   end

   // Capture the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_key_ff   <= in_key;
         in_count_ff <= in_count;
         in_end_ff   <= in_end;
      end
   end

   // Head memory write and registered scan read
   always_ff @(posedge clock) begin
      if (head_we && !in_end_ff) begin
         head_mem_ff[wr_idx] <= {in_key_ff, in_count_ff};
      end
      if (scan_issue) begin
         mem_q_ff <= head_mem_ff[scan_idx];
      end
   end

   // Merge control state
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff     <= '0;
         fill_ff     <= '0;
         merging_ff  <= 1'b0;
         pending_ff  <= '0;
         finished_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
         if (cmd.load && !finished_ff && !merging_ff) begin
            fill_ff <= fill_nx;
            if (!fill_more) begin
               merging_ff <= 1'b1;
            end
         end
         if (emit_rec) begin
            pending_ff <= best_idx_ff;
         end
         if (cmd.emit && !finished_ff && !found_ff) begin
            finished_ff <= 1'b1;
         end
      end
   end

   // Serial minimum scan; strict less-than keeps the lowest index on ties
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         rd_pend_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else if (cmd.load) begin
         scan_ff    <= '0;
         rd_pend_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         rd_pend_ff <= scan_issue;
         if (scan_issue) begin
            scan_ff <= scan_ff + CFG_W'(1);
         end
         if (take_best) begin
            found_ff <= 1'b1;
         end
      end
   end

   // Scan payload: read tag and current winner
   always_ff @(posedge clock) begin
      if (scan_issue) begin
         rd_live_ff <= live_ff[scan_idx];
         rd_idx_ff  <= scan_idx;
      end
      if (take_best) begin
         best_key_ff   <= rd_key;
         best_count_ff <= mem_q_ff[CNT_W-1:0];
         best_idx_ff   <= rd_idx_ff;
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload: winner or the done beat
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (emit_rec) begin
            out_key_ff   <= best_key_ff;
            out_count_ff <= best_count_ff;
            out_valid_ff <= 1'b1;
            out_part_ff  <= best_idx_ff;
            out_done_ff  <= 1'b0;
         end else begin
            out_key_ff   <= '0;
            out_count_ff <= '0;
            out_valid_ff <= 1'b0;
            out_part_ff  <= '0;
            out_done_ff  <= 1'b1;
         end
      end
   end

   assign stat.finished  = finished_ff;
   assign stat.fill_more = fill_more;
   assign stat.scan_done = (scan_ff >= n_act) && !rd_pend_ff;
   assign stat.out_free  = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_key   = out_key_ff;
   assign rsp_out_count = out_count_ff;
   assign rsp_out_valid = out_valid_ff;
   assign rsp_next_part = kwsm_pkg::PART_W'(out_part_ff);
   assign rsp_all_done  = out_done_ff;

endmodule
